/* hdl/ctlpu_pkg.sv */
// Shared types, constants and the MAC hash for the client table update block.
// Used by every module of the block but ctlpu_ram; depends on nothing.
package ctlpu_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned APS_PER_SLOT_DEF = 8;
  localparam logic signed [7:0] MIN_SIGNAL_RST = -8'sd90;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [2:0] ST_REFRESH = 3'd0;
  localparam logic [2:0] ST_ADDED = 3'd1;
  localparam logic [2:0] ST_BELOW = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_DELETED = 3'd4;

  typedef struct packed {
    logic req_type;
    logic [47:0] client_mac;
    logic [47:0] ap_mac;
    logic signed [7:0] signal_level;
    logic [15:0] slot;
  } item_t;

  typedef struct packed {
    logic valid;
    logic [2:0] status;
    logic [9:0] slot;
    logic [2:0] ap_index;
  } res_t;

  function automatic logic [31:0] elf_hash(input logic [47:0] mac);
    logic [31:0] h;
    logic [31:0] b;
    logic [31:0] x;
    h = 32'd0;
    for (int k = 0; k < 6; k++) begin
      b = {{24{mac[8*k+7]}}, mac[8*k +: 8]};
      h = (h << 4) + b;
      x = h & 32'hF000_0000;
      h = h ^ (x >> 24);
      h = h & ~x;
    end
    return h;
  endfunction

endpackage

/* hdl/client_table_linear_probe_update.sv */
// Top level of the client sighting table: front end, queue, table sequencer, output beat.
// Depends on ctlpu_pkg, ctlpu_front, ctlpu_queue and ctlpu_back.
//
//   Channel  Handshake          Payload
//   in_      in_valid/in_stall  req_type, client_mac, ap_mac, signal_level, now_time, del_slot
//   out_     out_valid/out_stall status, slot, ap_index
//   cfg_     cfg_valid/cfg_ready min_signal write data
//
// The front end holds a report after its beat while it reduces the hash to a home slot,
// then, like a delete, until the queue takes it. The sequencer then starts from idle, reads
// and checks each probed slot, reads and checks each scanned AP entry (all APS_PER_SLOT
// when none matches) and hands over the result; a delete skips probing and scanning.
// After reset a pass clearing all TABLE_SLOTS*APS_PER_SLOT AP entries holds in_stall high.
// The result register accepts a new beat while the previous one is taken.
module client_table_linear_probe_update #(
  parameter int unsigned TABLE_SLOTS = ctlpu_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned APS_PER_SLOT = ctlpu_pkg::APS_PER_SLOT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [47:0]       in_client_mac,
  input  logic [47:0]       in_ap_mac,
  input  logic signed [7:0] in_signal_level,
  input  logic [31:0]       in_now_time,
  input  logic [9:0]        in_del_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [9:0]        out_slot,
  output logic [2:0]        out_ap_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_min_signal
);
  import ctlpu_pkg::*;

  logic signed [7:0] min_signal_r;
  logic hold;
  logic q_full, q_push, q_pop, q_valid;
  item_t push_item, q_item;
  res_t res;
  logic res_take;
  logic out_valid_r;
  logic [2:0] status_r;
  logic [9:0] slot_r;
  logic [2:0] ap_r;
  logic unused_time;

  assign cfg_ready = 1'b1;
  assign unused_time = ^in_now_time;
  assign res_take = (~out_valid_r | ~out_stall) & ~unused_time | (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_slot = slot_r;
  assign out_ap_index = ap_r;

  ctlpu_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_client_mac(in_client_mac), .in_ap_mac(in_ap_mac),
    .in_signal_level(in_signal_level), .in_del_slot(in_del_slot), .hold(hold),
    .q_full(q_full), .q_push(q_push), .q_item(push_item)
  );

  ctlpu_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .q_valid(q_valid), .q_item(q_item)
  );

  ctlpu_back #(.TABLE_SLOTS(TABLE_SLOTS), .APS_PER_SLOT(APS_PER_SLOT)) u_back (
    .clk(clk), .rst_n(rst_n), .min_signal(min_signal_r), .q_valid(q_valid),
    .q_item(q_item), .q_pop(q_pop), .clr_busy(hold), .res(res), .res_take(res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_signal_r <= MIN_SIGNAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_signal_r <= cfg_min_signal;
      end
      if (res_take) begin
        out_valid_r <= res.valid;
      end
    end
    if (res_take) begin
      status_r <= res.status;
      slot_r <= res.slot;
      ap_r <= res.ap_index;
    end
  end

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> in_stall) else $error("Input taken during clearing pass.");
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("Queue overflow.");
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_DELETED)) else $error("Illegal status.");
  a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_slot == 10'd0 && out_ap_index == 3'd0))
    else $error("Full status with nonzero slot.");
`endif
endmodule

/* hdl/ctlpu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ctlpu_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/ctlpu_front.sv */
// Front end: takes in input beats, hashes the client MAC and reduces it to a home slot
// with a reciprocal multiply and one correction step. Depends on ctlpu_pkg.
module ctlpu_front #(
  parameter int unsigned TABLE_SLOTS = ctlpu_pkg::TABLE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [47:0]           in_client_mac,
  input  logic [47:0]           in_ap_mac,
  input  logic signed [7:0]     in_signal_level,
  input  logic [9:0]            in_del_slot,
  input  logic                  hold,
  input  logic                  q_full,
  output logic                  q_push,
  output ctlpu_pkg::item_t      q_item
);
  import ctlpu_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

  logic busy_r, busy_nxt;
  logic red_r, red_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic [59:0] prod_r, prod_nxt;
  logic [1:0] k_r, k_nxt;
  item_t item_r, item_nxt;
  logic [31:0] hash;
  logic [27:0] quo;
  logic acc;

  assign in_stall = busy_r | hold;
  assign acc = in_valid & ~in_stall;
  assign hash = elf_hash(in_client_mac);
  assign quo = prod_r[59:32];
  assign q_push = busy_r & ~red_r & ~q_full;

  always_comb begin
    q_item = item_r;
    if (item_r.req_type == REQ_REPORT) begin
      q_item.slot = 16'(rem_r);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    red_nxt = red_r;
    rem_nxt = rem_r;
    prod_nxt = prod_r;
    k_nxt = k_r;
    item_nxt = item_r;
    if (acc) begin
      busy_nxt = 1'b1;
      item_nxt.req_type = in_req_type;
      item_nxt.client_mac = in_client_mac;
      item_nxt.ap_mac = in_ap_mac;
      item_nxt.signal_level = in_signal_level;
      item_nxt.slot = {6'd0, in_del_slot};
      rem_nxt = hash[27:0];
      k_nxt = 2'd2;
      red_nxt = (in_req_type == REQ_REPORT);
    end else if (red_r) begin
      case (k_r)
        2'd2: begin
          prod_nxt = {32'd0, rem_r} * {28'd0, RECIP};
          k_nxt = 2'd1;
        end
        2'd1: begin
          rem_nxt = rem_r - quo * 28'(TABLE_SLOTS);
          k_nxt = 2'd0;
        end
        default: begin
          if (rem_r >= 28'(TABLE_SLOTS)) begin
            rem_nxt = rem_r - 28'(TABLE_SLOTS);
          end
          red_nxt = 1'b0;
        end
      endcase
    end else if (q_push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      red_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      red_r <= red_nxt;
    end
    rem_r <= rem_nxt;
    prod_r <= prod_nxt;
    k_r <= k_nxt;
    item_r <= item_nxt;
  end
endmodule

/* hdl/ctlpu_queue.sv */
// Two-entry queue that decouples the front end from the table sequencer.
// Depends on ctlpu_pkg.
module ctlpu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ctlpu_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output ctlpu_pkg::item_t q_item
);
  import ctlpu_pkg::*;

  item_t ent_r [2];
  logic wp_r, wp_nxt;
  logic rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = ent_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end
endmodule

/* hdl/ctlpu_back.sv */
// Back end: clears the tables after reset, probes the slot table and scans the AP entries.
// Depends on ctlpu_pkg and ctlpu_ram.
module ctlpu_back #(
  parameter int unsigned TABLE_SLOTS = ctlpu_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned APS_PER_SLOT = ctlpu_pkg::APS_PER_SLOT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [7:0]    min_signal,
  input  logic                 q_valid,
  input  ctlpu_pkg::item_t     q_item,
  output logic                 q_pop,
  output logic                 clr_busy,
  output ctlpu_pkg::res_t      res,
  input  logic                 res_take
);
  import ctlpu_pkg::*;

  localparam int unsigned TOT = TABLE_SLOTS * APS_PER_SLOT;
  localparam int unsigned SW = $clog2(TABLE_SLOTS);
  localparam int unsigned OW = (APS_PER_SLOT > 1) ? $clog2(APS_PER_SLOT) : 1;
  localparam int unsigned NW = $clog2(APS_PER_SLOT + 1);
  localparam int unsigned PW = $clog2(TOT);
  localparam int unsigned SLW = 1 + OW + 48;
  localparam int unsigned APW = 49;

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PRD = 3'd2;
  localparam logic [2:0] S_PCHK = 3'd3;
  localparam logic [2:0] S_ARD = 3'd4;
  localparam logic [2:0] S_ACHK = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  item_t it_r, it_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW:0] tcnt_r, tcnt_nxt;
  logic [NW-1:0] apn_r, apn_nxt;
  logic [OW-1:0] off_r, off_nxt;
  res_t res_r, res_nxt;

  logic s_we;
  logic [SW-1:0] s_waddr;
  logic [SLW-1:0] s_wdata, s_rdata;
  logic a_we;
  logic [PW-1:0] a_waddr, a_raddr;
  logic [APW-1:0] a_wdata, a_rdata;
  logic [OW-1:0] rd_off;
  logic [OW-1:0] off_inc;

  assign rd_off = s_rdata[SLW-2 -: OW];
  assign off_inc = (32'(off_r) == APS_PER_SLOT - 1) ? '0 : off_r + 1'b1;
  assign a_raddr = PW'(32'(idx_r) * APS_PER_SLOT + 32'(apn_r));
  assign clr_busy = (state_r == S_CLR);
  assign res = res_r;

  ctlpu_ram #(.W(SLW), .D(TABLE_SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(idx_r), .rdata(s_rdata)
  );

  ctlpu_ram #(.W(APW), .D(TOT)) u_ap_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    it_nxt = it_r;
    idx_nxt = idx_r;
    tcnt_nxt = tcnt_r;
    apn_nxt = apn_r;
    off_nxt = off_r;
    res_nxt = res_r;
    q_pop = 1'b0;
    s_we = 1'b0;
    s_waddr = idx_r;
    s_wdata = '0;
    a_we = 1'b0;
    a_waddr = PW'(32'(idx_r) * APS_PER_SLOT + 32'(off_r));
    a_wdata = '0;
    case (state_r)
      S_CLR: begin
        a_we = 1'b1;
        a_waddr = clr_r;
        s_we = (32'(clr_r) < TABLE_SLOTS);
        s_waddr = clr_r[SW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == TOT - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          it_nxt = q_item;
          idx_nxt = q_item.slot[SW-1:0];
          tcnt_nxt = '0;
          if (q_item.req_type == REQ_DELETE) begin
            s_we = (32'(q_item.slot) < TABLE_SLOTS);
            s_waddr = q_item.slot[SW-1:0];
            res_nxt = '{valid: 1'b1, status: ST_DELETED, slot: q_item.slot[9:0],
                        ap_index: 3'd0};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PRD;
          end
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!s_rdata[SLW-1] || s_rdata[47:0] == it_r.client_mac) begin
          if (!s_rdata[SLW-1]) begin
            s_we = 1'b1;
            s_wdata = {1'b1, rd_off, it_r.client_mac};
          end
          off_nxt = rd_off;
          if (it_r.signal_level < min_signal) begin
            res_nxt = '{valid: 1'b1, status: ST_BELOW, slot: 10'(32'(idx_r)),
                        ap_index: 3'd0};
            state_nxt = S_OUT;
          end else begin
            apn_nxt = '0;
            state_nxt = S_ARD;
          end
        end else if (32'(tcnt_r) == TABLE_SLOTS - 1) begin
          res_nxt = '{valid: 1'b1, status: ST_FULL, slot: 10'd0, ap_index: 3'd0};
          state_nxt = S_OUT;
        end else begin
          tcnt_nxt = tcnt_r + 1'b1;
          idx_nxt = (32'(idx_r) == TABLE_SLOTS - 1) ? '0 : idx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_ARD: begin
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        if (a_rdata[48] && a_rdata[47:0] == it_r.ap_mac) begin
          res_nxt = '{valid: 1'b1, status: ST_REFRESH, slot: 10'(32'(idx_r)),
                      ap_index: 3'(32'(apn_r))};
          state_nxt = S_OUT;
        end else if (32'(apn_r) == APS_PER_SLOT - 1) begin
          a_we = 1'b1;
          a_wdata = {1'b1, it_r.ap_mac};
          s_we = 1'b1;
          s_wdata = {1'b1, off_inc, it_r.client_mac};
          res_nxt = '{valid: 1'b1, status: ST_ADDED, slot: 10'(32'(idx_r)),
                      ap_index: 3'(32'(off_r))};
          state_nxt = S_OUT;
        end else begin
          apn_nxt = apn_r + 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_OUT: begin
        if (res_take) begin
          res_nxt.valid = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      res_r.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      res_r.valid <= res_nxt.valid;
    end
    res_r.status <= res_nxt.status;
    res_r.slot <= res_nxt.slot;
    res_r.ap_index <= res_nxt.ap_index;
    it_r <= it_nxt;
    idx_r <= idx_nxt;
    tcnt_r <= tcnt_nxt;
    apn_r <= apn_nxt;
    off_r <= off_nxt;
  end
endmodule
